/* design/assert_macros.svh */
// Assertion macros used by the top-level framer design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define YBF_ASSERT_IMPL(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define YBF_ASSERT_NEXT(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error(msg);

`endif

/* design/ybf_pkg.sv */
// Shared constants, types and the CRC function of the YMODEM block framer.
`timescale 1ns / 1ps

package ybf_pkg;

   // Block lengths in payload slots.
   localparam int LONG_BLOCK_BYTES  = 1024;
   localparam int SHORT_BLOCK_BYTES = 128;

   // Slot counter holds up to the long block length itself.
   localparam int SLOT_W = $clog2(LONG_BLOCK_BYTES) + 1;

   // Queue between the slot front end and the byte back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // Byte and CRC widths.
   localparam int BYTE_W = 8;
   localparam int CRC_W  = 16;

   // Framing bytes and CRC-16/XMODEM constants.
   localparam logic [BYTE_W-1:0] SOH_BYTE = 8'h01;
   localparam logic [BYTE_W-1:0] STX_BYTE = 8'h02;
   localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h1A;
   localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;
   localparam logic [CRC_W-1:0]  CRC_INIT = 16'h0000;

   // One classified slot, as handed from the front end to the back end.
   typedef struct packed {
      logic              first;
      logic              last;
      logic              short_mode;
      logic [BYTE_W-1:0] block_number;
      logic [BYTE_W-1:0] data;
      logic [CRC_W-1:0]  crc;
   } qentry_type;

   // Queue status seen by both neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // Feed one byte into a CRC-16/XMODEM, MSB first.
   function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* design/ybf_req_if.sv */
// Slot input channel: valid/ready handshake with the slot payload.
`timescale 1ns / 1ps

interface ybf_req_if import ybf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              is_payload;
   logic [BYTE_W-1:0] block_number;
   logic              short_block;

   modport source (output valid, output data_byte, output is_payload,
                   output block_number, output short_block, input ready);
   modport sink   (input valid, input data_byte, input is_payload,
                   input block_number, input short_block, output ready);
endinterface

/* design/ybf_rsp_if.sv */
// Framed byte output channel: valid/ready handshake with one wire byte.
`timescale 1ns / 1ps

interface ybf_rsp_if import ybf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              frame_end;
   logic              run_last;

   modport source (output valid, output out_byte, output frame_end,
                   output run_last, input ready);
   modport sink   (input valid, input out_byte, input frame_end,
                   input run_last, output ready);
endinterface

/* design/ymodem_block_framer.sv */
// YMODEM block framer: slots in, framed wire bytes with CRC-16/XMODEM out.
//
// req_ch carries one payload slot per transfer: the data byte, a payload or
// pad flag, and the block number and block size, which count only on the
// first slot of a block. rsp_ch carries one wire byte per transfer, with
// frame_end on the CRC low byte and run_last on the final byte of each slot.
// The first slot of a block yields the start byte, the block number, its
// complement and the data byte; the last slot yields the data byte and the
// two CRC bytes; other slots yield the data byte alone.
// With the queue empty, a slot is written into the queue and its first byte
// then into the back-end output register before rsp_ch.valid rises.
// Throughput: one wire byte per cycle while a slot is queued and the
// receiver is ready, set by the single output register of the back end.
// The four-entry slot queue absorbs the longer first and closing slots.
// Reset closes any open block, empties the queue and drops rsp_ch.valid.
// When the receiver stalls, the output byte holds, the queue fills, and
// req_ch.ready falls once all four entries are taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ymodem_block_framer import ybf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ybf_req_if.sink   req_ch,
   ybf_rsp_if.source rsp_ch
);

   qentry_type q_entry;
   qentry_type q_head;
   qstat_type  q_stat;
   logic       q_push;
   logic       q_pop;

   // Slot classification and CRC.
   ybf_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_stat  (q_stat),
      .q_push  (q_push),
      .q_entry (q_entry)
   );

   // Decoupling queue.
   ybf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head_entry (q_head),
      .stat       (q_stat)
   );

   // Byte sequencing and output register.
   ybf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (q_head),
      .q_stat     (q_stat),
      .q_pop      (q_pop),
      .rsp_ch     (rsp_ch)
   );

   `YBF_ASSERT_IMPL(a_no_push_when_full, q_push, !q_stat.full, "slot pushed into full queue")
   `YBF_ASSERT_IMPL(a_no_pop_when_empty, q_pop, !q_stat.empty, "pop from empty queue")
   `YBF_ASSERT_IMPL(a_frame_end_is_last, rsp_ch.valid && rsp_ch.frame_end, rsp_ch.run_last, "frame end not last byte of slot")
   `YBF_ASSERT_NEXT(a_no_double_end, rsp_ch.valid && rsp_ch.ready && rsp_ch.frame_end, !(rsp_ch.valid && rsp_ch.frame_end), "two frame ends in a row")

endmodule

/* design/ybf_front.sv */
// Slot front end: tracks the open block, runs the CRC and classifies each slot.
`timescale 1ns / 1ps

module ybf_front import ybf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ybf_req_if.sink    req_ch,
   input  qstat_type  q_stat,
   output logic       q_push,
   output qentry_type q_entry
);

   logic [SLOT_W-1:0] slot_count_ff, slot_count_in;
   logic              short_mode_ff, short_mode_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;

   logic              first;
   logic              mode;
   logic [CRC_W-1:0]  crc_base;
   logic [CRC_W-1:0]  crc_next;
   logic [BYTE_W-1:0] slot_byte;
   logic [SLOT_W-1:0] count_next;
   logic [SLOT_W-1:0] block_len;
   logic              last;

   // A slot is taken whenever the queue has room.
   assign req_ch.ready = !q_stat.full;
   assign q_push       = req_ch.valid && !q_stat.full;

   // Classify the slot against the open block.
   always_comb begin
      first      = (slot_count_ff == '0);
      mode       = first ? req_ch.short_block : short_mode_ff;
      crc_base   = first ? CRC_INIT : crc_ff;
      slot_byte  = req_ch.is_payload ? req_ch.data_byte : PAD_BYTE;
      crc_next   = crc_feed(crc_base, slot_byte);
      count_next = slot_count_ff + SLOT_W'(1);
      block_len  = mode ? SLOT_W'(SHORT_BLOCK_BYTES) : SLOT_W'(LONG_BLOCK_BYTES);
      last       = (count_next >= block_len);
   end

   // Entry handed to the back end.
   always_comb begin
      q_entry.first        = first;
      q_entry.last         = last;
      q_entry.short_mode   = mode;
      q_entry.block_number = req_ch.block_number;
      q_entry.data         = slot_byte;
      q_entry.crc          = crc_next;
   end

   // Block state advances on every transfer.
   always_comb begin
      slot_count_in = slot_count_ff;
      short_mode_in = short_mode_ff;
      crc_in        = crc_ff;
      if (q_push) begin
         slot_count_in = last ? '0 : count_next;
         short_mode_in = mode;
         crc_in        = crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= '0;
         short_mode_ff <= 1'b0;
         crc_ff        <= CRC_INIT;
      end else begin
         slot_count_ff <= slot_count_in;
         short_mode_ff <= short_mode_in;
         crc_ff        <= crc_in;
      end
   end

endmodule

/* design/ybf_queue.sv */
// Short queue of classified slots between the front end and the back end.
`timescale 1ns / 1ps

module ybf_queue import ybf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  qentry_type push_entry,
   input  logic       pop,
   output qentry_type head_entry,
   output qstat_type  stat
);

   qentry_type        slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // Status and head of the queue.
   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* design/ybf_back.sv */
// Byte back end: expands queued slots to wire bytes, one per unstalled cycle.
`timescale 1ns / 1ps

module ybf_back import ybf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  qentry_type head_entry,
   input  qstat_type  q_stat,
   output logic       q_pop,
   ybf_rsp_if.source  rsp_ch
);

   typedef enum logic [5:0] {
      BK_HEAD = 6'b000001,
      BK_NUM  = 6'b000010,
      BK_CPL  = 6'b000100,
      BK_DATA = 6'b001000,
      BK_CRCH = 6'b010000,
      BK_CRCL = 6'b100000
   } bk_state_type;

   bk_state_type      state_ff, state_in, state_next;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              frame_end_ff, frame_end_in;
   logic              run_last_ff, run_last_in;
   logic              advance;

   // The output register takes a new byte when it is empty or being drained.
   assign advance = !q_stat.empty && (!valid_ff || rsp_ch.ready);
   assign q_pop   = advance && run_last_in;

   // Select the byte of the current step of the head slot.
   always_comb begin
      byte_in      = head_entry.data;
      frame_end_in = 1'b0;
      run_last_in  = 1'b0;
      state_next   = state_ff;
      unique case (state_ff)
         BK_HEAD: begin
            if (head_entry.first) begin
               byte_in    = head_entry.short_mode ? SOH_BYTE : STX_BYTE;
               state_next = BK_NUM;
            end else if (head_entry.last) begin
               state_next = BK_CRCH;
            end else begin
               run_last_in = 1'b1;
               state_next  = BK_HEAD;
            end
         end
         BK_NUM: begin
            byte_in    = head_entry.block_number;
            state_next = BK_CPL;
         end
         BK_CPL: begin
            byte_in    = ~head_entry.block_number;
            state_next = BK_DATA;
         end
         BK_DATA: begin
            if (head_entry.last) begin
               state_next = BK_CRCH;
            end else begin
               run_last_in = 1'b1;
               state_next  = BK_HEAD;
            end
         end
         BK_CRCH: begin
            byte_in    = head_entry.crc[CRC_W-1:BYTE_W];
            state_next = BK_CRCL;
         end
         BK_CRCL: begin
            byte_in      = head_entry.crc[BYTE_W-1:0];
            frame_end_in = 1'b1;
            run_last_in  = 1'b1;
            state_next   = BK_HEAD;
         end
         default: begin
            state_next = BK_HEAD;
         end
      endcase
   end

   // Step and output-valid update.
   always_comb begin
      state_in = advance ? state_next : state_ff;
      valid_in = advance || (valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_HEAD;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff      <= byte_in;
         frame_end_ff <= frame_end_in;
         run_last_ff  <= run_last_in;
      end
   end

   assign rsp_ch.valid     = valid_ff;
   assign rsp_ch.out_byte  = byte_ff;
   assign rsp_ch.frame_end = frame_end_ff;
   assign rsp_ch.run_last  = run_last_ff;

endmodule
